>>> rtl/sdw_pkg.sv
// Package for the sequence duplicate window: outcome codes, defaults and shared types.
// No dependencies; sdw_core and sequence_duplicate_window import it.
`default_nettype none

package sdw_pkg;

   localparam int MaxWindowDefault = 256;

   localparam logic [5:0]  SeqBitsReset    = 6'd16;
   localparam logic [8:0]  WindowSizeReset = 9'd256;
   localparam logic [30:0] PastMaxReset    = 31'd16384;

   localparam logic [5:0] SeqBitsMin = 6'd8;
   localparam logic [5:0] SeqBitsMax = 6'd32;

   localparam logic [1:0] RegSeqBits    = 2'd0;
   localparam logic [1:0] RegWindowSize = 2'd1;
   localparam logic [1:0] RegPastMax    = 2'd2;

   localparam logic [2:0] OutFirst        = 3'd0;
   localparam logic [2:0] OutAdvance      = 3'd1;
   localparam logic [2:0] OutJumpReset    = 3'd2;
   localparam logic [2:0] OutOldFresh     = 3'd3;
   localparam logic [2:0] OutOldRepeat    = 3'd4;
   localparam logic [2:0] OutTooOld       = 3'd5;
   localparam logic [2:0] OutAncientReset = 3'd6;
   localparam logic [2:0] OutNewestRepeat = 3'd7;

   typedef struct packed {
      logic [5:0]  seq_bits;
      logic [30:0] past_max;
   } sdw_cfg_type;

   typedef struct packed {
      logic       is_duplicate;
      logic [2:0] outcome;
   } sdw_result_type;

endpackage

`default_nettype wire

>>> rtl/sdw_req_if.sv
// Input channel of the sequence duplicate window: one sequence number per word.
// Depends on nothing.
`default_nettype none

interface sdw_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] seq;

   modport source (output valid, output seq, input ready);
   modport sink (input valid, input seq, output ready);
endinterface

`default_nettype wire

>>> rtl/sdw_rsp_if.sv
// Result channel of the sequence duplicate window: duplicate flag and outcome per word.
// Depends on nothing.
`default_nettype none

interface sdw_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_duplicate;
   logic [2:0] outcome;

   modport source (output valid, output is_duplicate, output outcome, input ready);
   modport sink (input valid, input is_duplicate, input outcome, output ready);
endinterface

`default_nettype wire

>>> rtl/sdw_core.sv
// Window state and combinational decision logic of the sequence duplicate window.
// Depends on sdw_pkg.
`default_nettype none

module sdw_core
   import sdw_pkg::*;
#(
   parameter int MAX_WINDOW = MaxWindowDefault
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               step_en,
   input  wire logic [31:0]                        step_seq,
   input  wire sdw_cfg_type                        cfg,
   input  wire logic [$clog2(MAX_WINDOW + 1)-1:0]  win_eff,
   input  wire logic                               win_clear,
   input  wire logic [$clog2(MAX_WINDOW + 1)-1:0]  win_clear_size,
   output sdw_result_type                          result
);

   localparam int IdxW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   logic                  have_any_ff, have_any_in;
   logic [31:0]           newest_ff, newest_in;
   logic [MAX_WINDOW-1:0] seen_ff, seen_in;

   logic [5:0]            bits;
   logic [31:0]           mask, sign, s, last, d, age, ws32, pm32;
   logic                  newer;
   logic [MAX_WINDOW-1:0] win_mask, clr_mask, shifted;

   always_comb begin
      priority if (cfg.seq_bits < SeqBitsMin) begin
         bits = SeqBitsMin;
      end else if (cfg.seq_bits > SeqBitsMax) begin
         bits = SeqBitsMax;
      end else begin
         bits = cfg.seq_bits;
      end
   end

   assign mask  = 32'hffff_ffff >> (SeqBitsMax - bits);
   assign sign  = 32'h0000_0001 << (bits - 6'd1);
   assign s     = step_seq & mask;
   assign last  = newest_ff & mask;
   assign d     = (s - last) & mask;
   assign age   = (last - s) & mask;
   assign ws32  = 32'(win_eff);
   assign pm32  = {1'b0, cfg.past_max};
   assign newer = ((d & sign) == 32'd0) || ((d == sign) && (s > last));

   always_comb begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
         win_mask[i] = (32'(i) < ws32);
         clr_mask[i] = (32'(i) < 32'(win_clear_size));
      end
   end

   assign shifted = (seen_ff << d[IdxW-1:0]) & win_mask;

   always_comb begin
      have_any_in = have_any_ff;
      newest_in   = newest_ff;
      seen_in     = seen_ff;
      result      = '{is_duplicate: 1'b0, outcome: OutFirst};

      priority if (!have_any_ff) begin
         result.outcome = OutFirst;
      end else if (d == 32'd0) begin
         result = '{is_duplicate: 1'b1, outcome: OutNewestRepeat};
      end else if (newer) begin
         result.outcome = (d < ws32) ? OutAdvance : OutJumpReset;
      end else if (age < ws32) begin
         if (seen_ff[age[IdxW-1:0]]) begin
            result = '{is_duplicate: 1'b1, outcome: OutOldRepeat};
         end else begin
            result.outcome = OutOldFresh;
         end
      end else if (age < pm32) begin
         result = '{is_duplicate: 1'b1, outcome: OutTooOld};
      end else begin
         result.outcome = OutAncientReset;
      end

      if (step_en) begin
         unique case (result.outcome)
            OutFirst, OutJumpReset, OutAncientReset: begin
               have_any_in = 1'b1;
               newest_in   = s;
               seen_in     = '0;
               seen_in[0]  = 1'b1;
            end
            OutAdvance: begin
               newest_in  = s;
               seen_in    = shifted;
               seen_in[0] = 1'b1;
            end
            OutOldFresh: begin
               seen_in[age[IdxW-1:0]] = 1'b1;
            end
            default: begin
               seen_in = seen_ff;
            end
         endcase
         seen_in = seen_in & win_mask;
      end else if (win_clear) begin
         seen_in = seen_ff & clr_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_any_ff <= 1'b0;
         newest_ff   <= '0;
         seen_ff     <= '0;
      end else begin
         have_any_ff <= have_any_in;
         newest_ff   <= newest_in;
         seen_ff     <= seen_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/sequence_duplicate_window.sv
// Sequence duplicate window: reports whether each packet sequence number is a duplicate.
// Input words pass through in_seq_ff, then the sdw_core decision, then rsp_data_ff.
// One word per cycle unless rsp_chan stalls; sdw_core updates its window per word.
// Synchronous active-high reset clears the bitmap, the newest number and both channels,
// and returns the registers to 16, 256 and 16384. Depends on sdw_pkg, sdw_core and the
// channel interfaces.
`default_nettype none

module sequence_duplicate_window
   import sdw_pkg::*;
#(
   parameter int MAX_WINDOW = MaxWindowDefault
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sdw_req_if.sink    req_chan,
   sdw_rsp_if.source  rsp_chan,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [30:0] csr_wdata
);

   localparam int WinW = $clog2(MAX_WINDOW + 1);

   logic [5:0]  seq_bits_ff;
   logic [8:0]  window_size_ff;
   logic [30:0] past_max_ff;

   logic        in_valid_ff;
   logic [31:0] in_seq_ff;
   logic        rsp_valid_ff;
   sdw_result_type rsp_data_ff;

   logic        advance;
   logic        win_clear;
   logic [31:0] win32, new_win32;
   logic [WinW-1:0] win_eff, win_clear_size;
   sdw_cfg_type     cfg;
   sdw_result_type  result;

   function automatic logic [31:0] clamp_window(input logic [8:0] ws);
      logic [31:0] w;
      w = 32'(ws);
      if (w == 32'd0) begin
         w = 32'd1;
      end else if (w > 32'(MAX_WINDOW)) begin
         w = 32'(MAX_WINDOW);
      end
      return w;
   endfunction

   assign win32          = clamp_window(window_size_ff);
   assign new_win32      = clamp_window(csr_wdata[8:0]);
   assign win_eff        = win32[WinW-1:0];
   assign win_clear_size = new_win32[WinW-1:0];
   assign win_clear      = csr_wr_en && (csr_index == RegWindowSize);
   assign cfg            = '{seq_bits: seq_bits_ff, past_max: past_max_ff};

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_bits_ff    <= SeqBitsReset;
         window_size_ff <= WindowSizeReset;
         past_max_ff    <= PastMaxReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            RegSeqBits:    seq_bits_ff    <= csr_wdata[5:0];
            RegWindowSize: window_size_ff <= csr_wdata[8:0];
            RegPastMax:    past_max_ff    <= csr_wdata;
            default:       seq_bits_ff    <= seq_bits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_seq_ff <= req_chan.seq;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   sdw_core #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .step_en        (advance),
      .step_seq       (in_seq_ff),
      .cfg            (cfg),
      .win_eff        (win_eff),
      .win_clear      (win_clear),
      .win_clear_size (win_clear_size),
      .result         (result)
   );

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.is_duplicate = rsp_data_ff.is_duplicate;
   assign rsp_chan.outcome      = rsp_data_ff.outcome;

endmodule

`default_nettype wire
